// File: design/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg: shared types and entity tables for the HTML entity decoder
// Holds the sequencer state type, the match unit result and the entity tables.
// ----------------------------------------------------------------------------
package hed_pkg;

	localparam int ENT_COUNT  = 5;
	localparam int ENT_MAXLEN = 6;
	localparam int HOLD_DEPTH = 5;

	localparam logic [7:0] CHR_AMP = 8'h26;

	// Entity text, padded with zero past its length
	localparam logic [0:ENT_COUNT-1][0:ENT_MAXLEN-1][7:0] ENT_TEXT = '{
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},	// &quot;
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},	// &apos;
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},	// &amp;
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},	// &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}	// &gt;
	};

	localparam logic [0:ENT_COUNT-1][2:0] ENT_LEN = '{3'd6, 3'd6, 3'd5, 3'd4, 3'd4};

	localparam logic [0:ENT_COUNT-1][7:0] ENT_CHAR = '{8'h22, 8'h27, 8'h26, 8'h3c, 8'h3e};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BYTE,
		ST_REPLAY,
		ST_FLUSH
	} hed_state_t;

	typedef struct packed {
		logic [ENT_COUNT-1:0] hit;	// entities still matching after this byte
		logic                 full;	// one entity matched completely
		logic                 prefix;	// still a proper prefix of some entity
		logic [7:0]           chr;	// replacement character on a full match
	} hed_match_t;

endpackage

// File: design/html_entity_decoder_unit.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_unit: streaming HTML character entity decoder
// Replaces &quot; &apos; &amp; &lt; &gt; in a byte stream by their characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (in_valid/in_ready): one word per string byte, in_last on
//   the final byte. Output channel (out_valid/out_ready): decoded bytes,
//   out_last on the final decoded byte of the string.
//   in_ready is high only while the sequencer is idle; one input word is
//   worked on at a time by a single compare unit stepped by the sequencer.
//   A plain byte or a byte that extends or completes an entity is accepted,
//   then compared. A byte that breaks a partial match first emits the literal
//   '&', then replays the held bytes after it one at a time (up to 4), then is
//   compared anew. A final byte that is held also flushes every held byte (up
//   to 5). The worst case is a full hold broken by a final '&', which is then
//   held and flushed on its own.
//   Results sit in a single output register, so the next word may be taken
//   while a result still waits; the sequencer stalls only when it must emit
//   and the output register is full and not being taken.
//   Reset (arst_n low) clears the sequencer, the hold count and out_valid;
//   the held bytes themselves are not cleared.
// ----------------------------------------------------------------------------
module html_entity_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import hed_pkg::*;

	hed_state_t           state_q, state_d;
	logic [2:0]           held_count_q, held_count_d;
	logic [2:0]           idx_q, idx_d;
	logic [ENT_COUNT-1:0] mask_q, mask_d;
	logic [7:0]           held_q [HOLD_DEPTH];
	logic [7:0]           byte_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic                 can_emit;
	logic                 emit;
	logic [7:0]           emit_byte;
	logic                 emit_last;
	logic                 hold_wr;
	logic                 accept;
	logic [7:0]           held_rd;
	hed_match_t           mres;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign can_emit  = !out_valid_q || out_ready;
	assign held_rd   = held_q[idx_q];
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// Shared compare unit: the stored byte against column held_count
	hed_match u_match (
		.cand_byte (byte_q),
		.pos       (held_count_q),
		.mask      (mask_q),
		.res       (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_count_q <= '0;
			idx_q        <= '0;
			mask_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			held_count_q <= held_count_d;
			idx_q        <= idx_d;
			mask_q       <= mask_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers: input word, hold buffer, output word
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (hold_wr)
			held_q[held_count_q] <= byte_q;
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	always_comb begin
		state_d      = state_q;
		held_count_d = held_count_q;
		idx_d        = idx_q;
		mask_d       = mask_q;
		emit         = 1'b0;
		emit_byte    = byte_q;
		emit_last    = 1'b0;
		hold_wr      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_BYTE;
			end
			ST_BYTE: begin
				if (held_count_q == 3'd0) begin
					if (byte_q == CHR_AMP) begin
						// open a new partial match
						hold_wr      = 1'b1;
						held_count_d = 3'd1;
						mask_d       = '1;
						idx_d        = '0;
						state_d      = last_q ? ST_FLUSH : ST_IDLE;
					end else if (can_emit) begin
						emit      = 1'b1;
						emit_last = last_q;
						state_d   = ST_IDLE;
					end
				end else if (mres.full) begin
					if (can_emit) begin
						emit         = 1'b1;
						emit_byte    = mres.chr;
						emit_last    = last_q;
						held_count_d = '0;
						state_d      = ST_IDLE;
					end
				end else if (mres.prefix) begin
					// grow the partial match
					hold_wr      = 1'b1;
					held_count_d = held_count_q + 3'd1;
					mask_d       = mres.hit;
					idx_d        = '0;
					state_d      = last_q ? ST_FLUSH : ST_IDLE;
				end else if (can_emit) begin
					// broken match: drop the ampersand as a literal, replay the rest
					emit      = 1'b1;
					emit_byte = CHR_AMP;
					idx_d     = 3'd1;
					if (held_count_q == 3'd1)
						held_count_d = '0;
					else
						state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				// held bytes after the ampersand are letters only, never a new '&'
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = held_rd;
					idx_d     = idx_q + 3'd1;
					if (idx_q == held_count_q - 3'd1) begin
						held_count_d = '0;
						state_d      = ST_BYTE;
					end
				end
			end
			ST_FLUSH: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = held_rd;
					idx_d     = idx_q + 3'd1;
					if (idx_q == held_count_q - 3'd1) begin
						emit_last    = 1'b1;
						held_count_d = '0;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_hold_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= 3'(HOLD_DEPTH))
		else $error("hold count beyond buffer depth");

	a_accept_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_BYTE))
		else $error("accepted word not taken to the compare step");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (held_count_q != 3'd0 && idx_q < held_count_q))
		else $error("flush with nothing held");

	a_replay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLAY) |-> (idx_q != 3'd0 && idx_q < held_count_q))
		else $error("replay index out of range");

endmodule

// File: design/hed_match.sv
// ----------------------------------------------------------------------------
// hed_match: entity compare unit
// Compares one byte against column pos of every entity still in the running.
// ----------------------------------------------------------------------------
module hed_match (
	input  logic [7:0]                  cand_byte,
	input  logic [2:0]                  pos,
	input  logic [hed_pkg::ENT_COUNT-1:0] mask,
	output hed_pkg::hed_match_t         res
);
	import hed_pkg::*;

	always_comb begin
		res = '0;
		for (int k = 0; k < ENT_COUNT; k++) begin
			if (mask[k] && (ENT_LEN[k] > pos) && (ENT_TEXT[k][pos] == cand_byte)) begin
				res.hit[k] = 1'b1;
				if (ENT_LEN[k] == pos + 3'd1) begin
					res.full = 1'b1;
					res.chr  = ENT_CHAR[k];
				end
			end
		end
		res.prefix = (|res.hit) && !res.full;
	end

endmodule
